[design/tlqs_pkg.sv]
// Shared constants and types for the thick line quad setup block.
// No dependencies; every other file imports this package.
package tlqs_pkg;

  // field formats
  localparam int COORD_W         = 24;
  localparam int COORD_FRAC_BITS = 8;
  localparam int WIDTH_W         = 8;
  localparam int DIR_FRAC_BITS   = 14;
  localparam int DIR_W           = 16;

  // length is kept with extra fraction bits before the divide
  localparam int LEN_EXTRA_BITS  = 7;

  // span magnitude, square and radicand widths
  localparam int SPAN_W     = COORD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * SPAN_W;
  localparam int RAD_W      = SQ_W + 1 + 2 * LEN_EXTRA_BITS;
  localparam int ROOT_STEPS = (RAD_W + 1) / 2;
  localparam int LEN_W      = ROOT_STEPS;

  // divider widths: quotient never exceeds one in Q1.DIR_FRAC_BITS
  localparam int QUOT_W = DIR_FRAC_BITS + 1;
  localparam int NUM_W  = SPAN_W + DIR_FRAC_BITS + LEN_EXTRA_BITS + 1;
  localparam int REM_W  = LEN_W + 1;
  localparam logic [QUOT_W-1:0] DIR_ONE = QUOT_W'(1) << DIR_FRAC_BITS;

  // offset product and corner sum widths
  localparam int PROD_W = WIDTH_W + COORD_FRAC_BITS + QUOT_W;
  localparam int SUM_W  = COORD_W + 2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified segment
  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [WIDTH_W-1:0]        w;
    logic                      neg_x;
    logic                      neg_y;
    logic [SPAN_W-1:0]         adx;
    logic [SPAN_W-1:0]         ady;
    logic                      degen;
    logic [SPAN_W-1:0]         major;
  } tlqs_geom_t;

endpackage

[design/tlqs_front.sv]
// Front end: accepts segment words, forms spans, magnitudes and the major length.
// Depends on tlqs_pkg; feeds tlqs_queue.
module tlqs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tlqs_pkg::COORD_W-1:0] start_x,
  input  logic signed [tlqs_pkg::COORD_W-1:0] start_y,
  input  logic signed [tlqs_pkg::COORD_W-1:0] end_x,
  input  logic signed [tlqs_pkg::COORD_W-1:0] end_y,
  input  logic [tlqs_pkg::WIDTH_W-1:0]        line_width,
  input  logic                                q_full,
  output logic                                push,
  output tlqs_pkg::tlqs_geom_t                push_word
);
  import tlqs_pkg::*;

  logic                      f1_v;
  logic signed [COORD_W-1:0] f1_sx, f1_sy, f1_ex, f1_ey;
  logic [WIDTH_W-1:0]        f1_w;
  logic signed [DIFF_W-1:0]  f1_dx, f1_dy;
  logic                      f2_v;
  tlqs_geom_t                f2_g;
  logic                      fen;
  logic [SPAN_W-1:0]         adx, ady;

  // hold both stages while stage two holds a word and the queue is full
  assign fen      = !(f2_v && q_full);
  assign in_stall = !fen;
  assign push     = f2_v && !q_full;
  assign push_word = f2_g;

  assign adx = f1_dx[DIFF_W-1] ? SPAN_W'(-f1_dx) : SPAN_W'(f1_dx);
  assign ady = f1_dy[DIFF_W-1] ? SPAN_W'(-f1_dy) : SPAN_W'(f1_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else if (fen) begin
      f1_v <= in_valid;
      f2_v <= f1_v;
    end
  end

  // span stage
  always_ff @(posedge clk) begin
    if (fen) begin
      f1_sx <= start_x;
      f1_sy <= start_y;
      f1_ex <= end_x;
      f1_ey <= end_y;
      f1_w  <= line_width;
      f1_dx <= DIFF_W'(end_x) - DIFF_W'(start_x);
      f1_dy <= DIFF_W'(end_y) - DIFF_W'(start_y);
    end
  end

  // magnitude and classification stage
  always_ff @(posedge clk) begin
    if (fen) begin
      f2_g.sx    <= f1_sx;
      f2_g.sy    <= f1_sy;
      f2_g.ex    <= f1_ex;
      f2_g.ey    <= f1_ey;
      f2_g.w     <= f1_w;
      f2_g.neg_x <= f1_dx[DIFF_W-1];
      f2_g.neg_y <= f1_dy[DIFF_W-1];
      f2_g.adx   <= adx;
      f2_g.ady   <= ady;
      f2_g.degen <= (adx == '0) && (ady == '0);
      f2_g.major <= (adx > ady) ? adx : ady;
    end
  end

endmodule

[design/tlqs_queue.sv]
// Short queue of classified segment words between front and back.
// Depends on tlqs_pkg.
module tlqs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tlqs_pkg::tlqs_geom_t push_word,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_ok,
  output tlqs_pkg::tlqs_geom_t head
);
  import tlqs_pkg::*;

  tlqs_geom_t        mem [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_ok = (count != '0);
  assign head    = mem[rd_ptr];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

endmodule

[design/tlqs_back.sv]
// Back end: square root, direction divide, offsets and saturated corners.
// Depends on tlqs_pkg; takes words from tlqs_queue.
module tlqs_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                head_ok,
  input  tlqs_pkg::tlqs_geom_t                head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner0_x,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner0_y,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner1_x,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner1_y,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner2_x,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner2_y,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner3_x,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner3_y,
  output logic signed [tlqs_pkg::DIR_W-1:0]   unit_dir_x,
  output logic signed [tlqs_pkg::DIR_W-1:0]   unit_dir_y,
  output logic [tlqs_pkg::COORD_W-1:0]        major_length,
  output logic                                degenerate
);
  import tlqs_pkg::*;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi)      sat = COORD_W'(hi);
    else if (v < lo) sat = COORD_W'(lo);
    else             sat = COORD_W'(v);
  endfunction

  logic en;

  // whole back pipeline moves when the output register is free
  assign en  = !out_valid || !out_stall;
  assign pop = en && head_ok;

  // squares
  logic              sq_v;
  tlqs_geom_t        sq_g;
  logic [SQ_W-1:0]   sq_x, sq_y;
  logic [SQ_W:0]     sq_sum;

  always_ff @(posedge clk) begin
    if (rst) sq_v <= 1'b0;
    else if (en) sq_v <= head_ok;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_g <= head;
      sq_x <= SQ_W'(head.adx) * SQ_W'(head.adx);
      sq_y <= SQ_W'(head.ady) * SQ_W'(head.ady);
    end
  end

  assign sq_sum = (SQ_W+1)'(sq_x) + (SQ_W+1)'(sq_y);

  // square root, one result bit per stage
  logic             rt_v [0:ROOT_STEPS];
  tlqs_geom_t       rt_g [0:ROOT_STEPS];
  logic [RAD_W-1:0] rt_n [0:ROOT_STEPS];
  logic [RAD_W-1:0] rt_r [0:ROOT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) rt_v[0] <= 1'b0;
    else if (en) rt_v[0] <= sq_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_g[0] <= sq_g;
      rt_n[0] <= {sq_sum, {(2*LEN_EXTRA_BITS){1'b0}}};
      rt_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic [RAD_W:0] trial;
    assign trial = {1'b0, rt_r[k]} + BIT;

    always_ff @(posedge clk) begin
      if (rst) rt_v[k+1] <= 1'b0;
      else if (en) rt_v[k+1] <= rt_v[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_g[k+1] <= rt_g[k];
        if ({1'b0, rt_n[k]} >= trial) begin
          rt_n[k+1] <= rt_n[k] - trial[RAD_W-1:0];
          rt_r[k+1] <= (rt_r[k] >> 1) + BIT[RAD_W-1:0];
        end else begin
          rt_n[k+1] <= rt_n[k];
          rt_r[k+1] <= rt_r[k] >> 1;
        end
      end
    end
  end

  // direction divide, one quotient bit per stage for both components
  logic              dv_v  [0:QUOT_W];
  tlqs_geom_t        dv_g  [0:QUOT_W];
  logic [LEN_W-1:0]  dv_len[0:QUOT_W];
  logic [REM_W-1:0]  dv_rx [0:QUOT_W];
  logic [REM_W-1:0]  dv_ry [0:QUOT_W];
  logic [QUOT_W-1:0] dv_lx [0:QUOT_W];
  logic [QUOT_W-1:0] dv_ly [0:QUOT_W];
  logic [QUOT_W-1:0] dv_qx [0:QUOT_W];
  logic [QUOT_W-1:0] dv_qy [0:QUOT_W];
  logic [LEN_W-1:0]  len;
  logic [NUM_W-1:0]  num_x, num_y;

  assign len   = rt_r[ROOT_STEPS][LEN_W-1:0];
  assign num_x = NUM_W'({rt_g[ROOT_STEPS].adx, {(DIR_FRAC_BITS+LEN_EXTRA_BITS){1'b0}}})
               + NUM_W'(len >> 1);
  assign num_y = NUM_W'({rt_g[ROOT_STEPS].ady, {(DIR_FRAC_BITS+LEN_EXTRA_BITS){1'b0}}})
               + NUM_W'(len >> 1);

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= rt_v[ROOT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_g[0]   <= rt_g[ROOT_STEPS];
      dv_len[0] <= len;
      dv_rx[0]  <= REM_W'(num_x[NUM_W-1:QUOT_W]);
      dv_ry[0]  <= REM_W'(num_y[NUM_W-1:QUOT_W]);
      dv_lx[0]  <= num_x[QUOT_W-1:0];
      dv_ly[0]  <= num_y[QUOT_W-1:0];
      dv_qx[0]  <= '0;
      dv_qy[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    logic [REM_W-1:0] tx, ty, dl;
    assign tx = {dv_rx[k][LEN_W-1:0], dv_lx[k][QUOT_W-1]};
    assign ty = {dv_ry[k][LEN_W-1:0], dv_ly[k][QUOT_W-1]};
    assign dl = {1'b0, dv_len[k]};

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (en) dv_v[k+1] <= dv_v[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_g[k+1]   <= dv_g[k];
        dv_len[k+1] <= dv_len[k];
        dv_lx[k+1]  <= dv_lx[k] << 1;
        dv_ly[k+1]  <= dv_ly[k] << 1;
        dv_rx[k+1]  <= (tx >= dl) ? tx - dl : tx;
        dv_ry[k+1]  <= (ty >= dl) ? ty - dl : ty;
        dv_qx[k+1]  <= {dv_qx[k][QUOT_W-2:0], tx >= dl};
        dv_qy[k+1]  <= {dv_qy[k][QUOT_W-2:0], ty >= dl};
      end
    end
  end

  // clamp, sign and offset products
  logic                    mu_v;
  tlqs_geom_t              mu_g;
  logic signed [DIR_W-1:0] mu_ux, mu_uy;
  logic [PROD_W-1:0]       mu_px, mu_py;
  logic [QUOT_W-1:0]       mx, my;
  tlqs_geom_t              dg;

  assign dg = dv_g[QUOT_W];
  assign mx = dg.degen ? '0 : (dv_qx[QUOT_W] > DIR_ONE ? DIR_ONE : dv_qx[QUOT_W]);
  assign my = dg.degen ? '0 : (dv_qy[QUOT_W] > DIR_ONE ? DIR_ONE : dv_qy[QUOT_W]);

  always_ff @(posedge clk) begin
    if (rst) mu_v <= 1'b0;
    else if (en) mu_v <= dv_v[QUOT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_g  <= dg;
      mu_ux <= dg.neg_x ? -DIR_W'(mx) : DIR_W'(mx);
      mu_uy <= dg.neg_y ? -DIR_W'(my) : DIR_W'(my);
      // x offset follows uy, y offset follows -ux
      mu_px <= PROD_W'({dg.w, {COORD_FRAC_BITS{1'b0}}}) * PROD_W'(my);
      mu_py <= PROD_W'({dg.w, {COORD_FRAC_BITS{1'b0}}}) * PROD_W'(mx);
    end
  end

  // round offsets and form saturated corners
  logic [PROD_W:0]         rx, ry;
  logic signed [SUM_W-1:0] offx, offy;

  assign rx   = ((PROD_W+1)'(mu_px) + ((PROD_W+1)'(1) << DIR_FRAC_BITS)) >> (DIR_FRAC_BITS + 1);
  assign ry   = ((PROD_W+1)'(mu_py) + ((PROD_W+1)'(1) << DIR_FRAC_BITS)) >> (DIR_FRAC_BITS + 1);
  assign offx = mu_g.neg_y ? -SUM_W'(rx) : SUM_W'(rx);
  assign offy = mu_g.neg_x ? SUM_W'(ry) : -SUM_W'(ry);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= mu_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      corner0_x    <= sat(SUM_W'(mu_g.sx) + offx);
      corner0_y    <= sat(SUM_W'(mu_g.sy) + offy);
      corner1_x    <= sat(SUM_W'(mu_g.ex) + offx);
      corner1_y    <= sat(SUM_W'(mu_g.ey) + offy);
      corner2_x    <= sat(SUM_W'(mu_g.sx) - offx);
      corner2_y    <= sat(SUM_W'(mu_g.sy) - offy);
      corner3_x    <= sat(SUM_W'(mu_g.ex) - offx);
      corner3_y    <= sat(SUM_W'(mu_g.ey) - offy);
      unit_dir_x   <= mu_ux;
      unit_dir_y   <= mu_uy;
      major_length <= mu_g.major;
      degenerate   <= mu_g.degen;
    end
  end

  // root of the scaled squared length fits the length register
  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    rt_v[ROOT_STEPS] |-> (rt_r[ROOT_STEPS][RAD_W-1:LEN_W] == '0))
    else $error("square root result wider than length");

  // quotient never passes one before the clamp
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (dv_v[QUOT_W] && !dg.degen) |-> (dv_qx[QUOT_W] <= DIR_ONE && dv_qy[QUOT_W] <= DIR_ONE))
    else $error("direction quotient above one");

  // a zero-length segment leaves a zero direction
  a_degen_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (unit_dir_x == '0 && unit_dir_y == '0 && major_length == '0))
    else $error("degenerate segment with nonzero direction");

endmodule

[design/thick_line_quad_setup_core.sv]
// Thick line quad setup: each word carries two Q15.8 endpoints and a whole
// pixel width and yields one word with four saturated quad corners, the Q1.14
// unit direction, the major-axis span and a degenerate flag. One word is
// accepted per cycle unless a full queue stalls the front, and results leave
// in order. A result word passes 55 registers (2 front stages, 1 queue write,
// 1 square stage, 33 square-root stages with the radicand load, 16 divide
// stages with the numerator load, 1 offset stage and the output register),
// most of them in the one-bit-per-stage square root and divider. A four-word
// queue parts the front from the back so either side may stall on its own.
// Depends on tlqs_pkg, tlqs_front, tlqs_queue, tlqs_back.
module thick_line_quad_setup_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tlqs_pkg::COORD_W-1:0] start_x,
  input  logic signed [tlqs_pkg::COORD_W-1:0] start_y,
  input  logic signed [tlqs_pkg::COORD_W-1:0] end_x,
  input  logic signed [tlqs_pkg::COORD_W-1:0] end_y,
  input  logic [tlqs_pkg::WIDTH_W-1:0]        line_width,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner0_x,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner0_y,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner1_x,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner1_y,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner2_x,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner2_y,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner3_x,
  output logic signed [tlqs_pkg::COORD_W-1:0] corner3_y,
  output logic signed [tlqs_pkg::DIR_W-1:0]   unit_dir_x,
  output logic signed [tlqs_pkg::DIR_W-1:0]   unit_dir_y,
  output logic [tlqs_pkg::COORD_W-1:0]        major_length,
  output logic                                degenerate
);
  import tlqs_pkg::*;

  logic       push, q_full, pop, head_ok;
  tlqs_geom_t push_word, head;

  tlqs_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .start_x, .start_y, .end_x, .end_y, .line_width,
    .q_full, .push, .push_word
  );

  tlqs_queue u_queue (
    .clk, .rst, .push, .push_word, .full(q_full),
    .pop, .head_ok, .head
  );

  tlqs_back u_back (
    .clk, .rst, .head_ok, .head, .pop, .out_valid, .out_stall,
    .corner0_x, .corner0_y, .corner1_x, .corner1_y,
    .corner2_x, .corner2_y, .corner3_x, .corner3_y,
    .unit_dir_x, .unit_dir_y, .major_length, .degenerate
  );

endmodule

[tb/sv/tb_thick_line_quad_setup_core.sv]
// Testbench for thick_line_quad_setup_core: drives segments through the
// valid/stall handshake and checks every result word against an in-bench
// quad setup predictor. Depends on tlqs_pkg and the core.
module tb_thick_line_quad_setup_core;
  import tlqs_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
    logic signed [DIR_W-1:0]   ux, uy;
    logic [COORD_W-1:0]        major;
    logic                      degen;
  } quad_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [WIDTH_W-1:0] line_width = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] corner0_x, corner0_y, corner1_x, corner1_y;
  logic signed [COORD_W-1:0] corner2_x, corner2_y, corner3_x, corner3_y;
  logic signed [DIR_W-1:0] unit_dir_x, unit_dir_y;
  logic [COORD_W-1:0] major_length;
  logic degenerate;

  quad_t pending_quads[$];
  int    fail_count = 0;
  bit    src_idle_en = 1'b0;
  bit    sink_idle_en = 1'b0;
  int    sink_hold = 0;
  int    hold_reqs = 0;
  int    hold_seen = 0;

  thick_line_quad_setup_core dut (.*);

  always #5 clk = ~clk;

  // integer square root, one result bit per pass
  function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint dir_part(longint d, longint unsigned len);
    longint unsigned m, q;
    m = (d < 0) ? -d : d;
    q = (((m << DIR_FRAC_BITS) << LEN_EXTRA_BITS) + (len >> 1)) / len;
    if (q > (64'd1 << DIR_FRAC_BITS)) q = 64'd1 << DIR_FRAC_BITS;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint half_width_shift(longint unsigned w, longint u);
    longint unsigned m, r;
    m = (w << COORD_FRAC_BITS) * ((u < 0) ? -u : u);
    r = (m + (64'd1 << DIR_FRAC_BITS)) >> (DIR_FRAC_BITS + 1);
    return (u < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[COORD_W-1:0];
  endfunction

  // predict the quad for one segment
  function automatic quad_t predict_quad(longint sx, longint sy, longint ex,
                                         longint ey, longint unsigned w);
    quad_t q;
    longint dx, dy, ux, uy, ox, oy;
    longint unsigned adx, ady, sq;
    dx = ex - sx;
    dy = ey - sy;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    sq = adx * adx + ady * ady;
    ux = 0;
    uy = 0;
    if (sq != 0) begin
      ux = dir_part(dx, root_of(sq << (2 * LEN_EXTRA_BITS)));
      uy = dir_part(dy, root_of(sq << (2 * LEN_EXTRA_BITS)));
    end
    ox = half_width_shift(w, uy);
    oy = half_width_shift(w, -ux);
    q.c0x = clamp24(sx + ox); q.c0y = clamp24(sy + oy);
    q.c1x = clamp24(ex + ox); q.c1y = clamp24(ey + oy);
    q.c2x = clamp24(sx - ox); q.c2y = clamp24(sy - oy);
    q.c3x = clamp24(ex - ox); q.c3y = clamp24(ey - oy);
    q.ux = ux[DIR_W-1:0];
    q.uy = uy[DIR_W-1:0];
    q.major = (adx > ady) ? adx[COORD_W-1:0] : ady[COORD_W-1:0];
    q.degen = (sq == 0);
    return q;
  endfunction

  // offer one word, hold it until accepted; valid drops only while idling
  task automatic send_segment(int sx, int sy, int ex, int ey, int w);
    logic signed [COORD_W-1:0] csx, csy, cex, cey;
    logic [WIDTH_W-1:0]        cw;
    csx = COORD_W'(sx);
    csy = COORD_W'(sy);
    cex = COORD_W'(ex);
    cey = COORD_W'(ey);
    cw  = WIDTH_W'(w);
    while (src_idle_en && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    start_x <= csx; start_y <= csy; end_x <= cex; end_y <= cey; line_width <= cw;
    pending_quads.push_back(predict_quad(csx, csy, cex, cey, cw));
    // stall is stable between edges, so it tells whether the next edge accepts
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_quads.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] rnd_coord();
    case ($urandom_range(3))
      0: return COORD_W'($urandom);
      1: return COORD_W'($signed(COORD_W'($urandom_range(2047))) - 1024);
      2: return $urandom_range(1) ? COORD_W'(24'sh7FFFFF - $urandom_range(3000))
                                  : COORD_W'(24'sh800000 + $urandom_range(3000));
      default: return COORD_W'($signed(COORD_W'($urandom_range(65535))) - 32768);
    endcase
  endfunction

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    quad_t q;
    if (!rst && out_valid && !out_stall) begin
      if (pending_quads.size() == 0) begin
        $error("result word with no prediction waiting");
        fail_count++;
      end else begin
        q = pending_quads.pop_front();
        if (corner0_x !== q.c0x) begin
          $error("corner0_x exp %0d got %0d", q.c0x, corner0_x); fail_count++;
        end
        if (corner0_y !== q.c0y) begin
          $error("corner0_y exp %0d got %0d", q.c0y, corner0_y); fail_count++;
        end
        if (corner1_x !== q.c1x) begin
          $error("corner1_x exp %0d got %0d", q.c1x, corner1_x); fail_count++;
        end
        if (corner1_y !== q.c1y) begin
          $error("corner1_y exp %0d got %0d", q.c1y, corner1_y); fail_count++;
        end
        if (corner2_x !== q.c2x) begin
          $error("corner2_x exp %0d got %0d", q.c2x, corner2_x); fail_count++;
        end
        if (corner2_y !== q.c2y) begin
          $error("corner2_y exp %0d got %0d", q.c2y, corner2_y); fail_count++;
        end
        if (corner3_x !== q.c3x) begin
          $error("corner3_x exp %0d got %0d", q.c3x, corner3_x); fail_count++;
        end
        if (corner3_y !== q.c3y) begin
          $error("corner3_y exp %0d got %0d", q.c3y, corner3_y); fail_count++;
        end
        if (unit_dir_x !== q.ux) begin
          $error("unit_dir_x exp %0d got %0d", q.ux, unit_dir_x); fail_count++;
        end
        if (unit_dir_y !== q.uy) begin
          $error("unit_dir_y exp %0d got %0d", q.uy, unit_dir_y); fail_count++;
        end
        if (major_length !== q.major) begin
          $error("major_length exp %0d got %0d", q.major, major_length); fail_count++;
        end
        if (degenerate !== q.degen) begin
          $error("degenerate exp %0d got %0d", q.degen, degenerate); fail_count++;
        end
      end
    end
  end

  // drive receiver stall: random idling or a counted long hold
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      sink_hold <= 300;
      out_stall <= 1'b1;
    end else if (sink_hold > 0) begin
      out_stall <= 1'b1;
      sink_hold <= sink_hold - 1;
    end else begin
      out_stall <= sink_idle_en && ($urandom_range(99) < 37);
    end
  end

  task automatic test_directed();
    logic signed [COORD_W-1:0] mx, mn;
    mx = 24'sh7FFFFF;
    mn = 24'sh800000;
    send_segment(0, 0, 0, 0, 0);
    send_segment(100, -50, 100, -50, 255);
    send_segment(mx, mx, mx, mx, 255);
    send_segment(mn, mn, mx, mx, 255);
    send_segment(mx, mx, mn, mn, 255);
    send_segment(mn, mx, mx, mn, 128);
    send_segment(mx, 0, mx, 256, 255);
    send_segment(mn, 0, mn, -256, 255);
    send_segment(0, mx, 256, mx, 255);
    send_segment(0, mn, -256, mn, 255);
    send_segment(0, 0, 1, 0, 1);
    send_segment(0, 0, 0, -1, 1);
    send_segment(0, 0, 1, 1, 3);
    send_segment(0, 0, -1, 2, 7);
    send_segment(0, 0, 3, 4, 255);
    send_segment(-1000, 2000, 1000, -2000, 17);
    send_segment(0, 0, 1, 1000000, 200);
    send_segment(0, 0, mx, 1, 200);
    send_segment(mn, mn, mn, mx, 1);
    send_segment(5, 5, 5, 6, 0);
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic signed [COORD_W-1:0] sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = rnd_coord();
      sy = rnd_coord();
      if ($urandom_range(19) == 0)
        send_segment(sx, sy, sx, sy, $urandom);
      else if ($urandom_range(1))
        send_segment(sx, sy, sx + rnd_coord(), sy + rnd_coord(), $urandom);
      else
        send_segment(sx, sy, rnd_coord(), rnd_coord(), $urandom);
    end
  endtask

  // hold the receiver long while the sender keeps offering
  task automatic test_backpressure();
    hold_reqs++;
    test_random(150);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(400);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    test_random(700);
    test_backpressure();
    test_random(650);
    wait_drained();
    repeat (120) @(posedge clk);
    if (fail_count == 0 && pending_quads.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
